[src/jan_pkg.sv]
package jan_pkg;

  // Width of a raw sample and of every calibration point.
  localparam int SAMPLE_BITS = 12;
  // The divider yields floor(d * 128 / D) with d <= D, which needs eight quotient bits.
  localparam int QUO_BITS    = 8;
  localparam int DIV_STEPS   = QUO_BITS;
  localparam int LEVEL_BITS  = 8;
  localparam int GRADE_BITS  = 3;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [LEVEL_BITS-1:0] LEVEL_MIN    = 8'd0;
  localparam logic [LEVEL_BITS-1:0] LEVEL_CENTRE = 8'd127;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX    = 8'd255;

  // Grade band edges; the last edge is inclusive.
  localparam logic [LEVEL_BITS-1:0] GRADE_EDGE_1 = 8'd18;
  localparam logic [LEVEL_BITS-1:0] GRADE_EDGE_2 = 8'd64;
  localparam logic [LEVEL_BITS-1:0] GRADE_EDGE_3 = 8'd96;
  localparam logic [LEVEL_BITS-1:0] GRADE_EDGE_4 = 8'd178;
  localparam logic [LEVEL_BITS-1:0] GRADE_EDGE_5 = 8'd229;
  localparam logic [LEVEL_BITS-1:0] GRADE_EDGE_6 = 8'd240;

  localparam logic [SAMPLE_BITS-1:0] RST_LOW    = 12'd0;
  localparam logic [SAMPLE_BITS-1:0] RST_CENTRE = 12'd2048;
  localparam logic [SAMPLE_BITS-1:0] RST_HIGH   = 12'd4095;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_X_LOW    = 3'd0,
    REG_X_CENTRE = 3'd1,
    REG_X_HIGH   = 3'd2,
    REG_Y_LOW    = 3'd3,
    REG_Y_CENTRE = 3'd4,
    REG_Y_HIGH   = 3'd5
  } cfg_idx_t;

  // Which segment of the transfer curve a sample falls in.
  typedef enum logic [2:0] {
    MODE_BELOW,
    MODE_LOWER,
    MODE_UPPER,
    MODE_FLAT,
    MODE_ABOVE
  } mode_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] x_sample;
    logic [SAMPLE_BITS-1:0] y_sample;
  } in_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] x_level;
    logic [LEVEL_BITS-1:0] y_level;
    logic [GRADE_BITS-1:0] x_grade;
    logic [GRADE_BITS-1:0] y_grade;
    logic                  calib_error;
  } out_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] x_low;
    logic [SAMPLE_BITS-1:0] x_centre;
    logic [SAMPLE_BITS-1:0] x_high;
    logic [SAMPLE_BITS-1:0] y_low;
    logic [SAMPLE_BITS-1:0] y_centre;
    logic [SAMPLE_BITS-1:0] y_high;
  } cal_t;

  // One axis in flight through the divider chain.
  typedef struct packed {
    logic [SAMPLE_BITS:0]   rem;
    logic [SAMPLE_BITS-1:0] div;
    logic [QUO_BITS-1:0]    quo;
    mode_t                  mode;
  } lane_t;

  typedef struct packed {
    lane_t x;
    lane_t y;
    logic  err;
  } stage_t;

endpackage

[src/jan_front.sv]
module jan_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  jan_pkg::in_t  up_data,
  input  jan_pkg::cal_t cal,
  output logic          dn_valid,
  input  logic          dn_ready,
  output jan_pkg::stage_t dn_data
);

  logic            valid_r;
  jan_pkg::stage_t data_r;
  jan_pkg::stage_t data_nxt;

  // Picks the curve segment and sets up dividend offset and divisor span.
  function automatic jan_pkg::lane_t setup(
    input logic [jan_pkg::SAMPLE_BITS-1:0] s,
    input logic [jan_pkg::SAMPLE_BITS-1:0] lo,
    input logic [jan_pkg::SAMPLE_BITS-1:0] mid,
    input logic [jan_pkg::SAMPLE_BITS-1:0] hi
  );
    jan_pkg::lane_t l;
    logic [jan_pkg::SAMPLE_BITS-1:0] d;
    l.quo  = '0;
    l.div  = '0;
    l.mode = jan_pkg::MODE_BELOW;
    d      = '0;
    if (s < lo) begin
      l.mode = jan_pkg::MODE_BELOW;
    end else if (s < mid) begin
      l.mode = jan_pkg::MODE_LOWER;
      d      = s - lo;
      l.div  = mid - lo;
    end else if (s <= hi) begin
      d     = s - mid;
      l.div = hi - mid;
      l.mode = (l.div == '0) ? jan_pkg::MODE_FLAT : jan_pkg::MODE_UPPER;
    end else begin
      l.mode = jan_pkg::MODE_ABOVE;
    end
    l.rem = {1'b0, d};
    return l;
  endfunction

  always_comb begin
    data_nxt.x   = setup(up_data.x_sample, cal.x_low, cal.x_centre, cal.x_high);
    data_nxt.y   = setup(up_data.y_sample, cal.y_low, cal.y_centre, cal.y_high);
    data_nxt.err = (cal.x_centre <= cal.x_low) || (cal.x_high <= cal.x_centre) ||
                   (cal.y_centre <= cal.y_low) || (cal.y_high <= cal.y_centre);
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

[src/jan_cell.sv]
module jan_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  jan_pkg::stage_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output jan_pkg::stage_t dn_data
);

  logic            valid_r;
  jan_pkg::stage_t data_r;
  jan_pkg::stage_t data_nxt;

  // One restoring step: compare, conditionally subtract, shift left.
  function automatic jan_pkg::lane_t step(input jan_pkg::lane_t l);
    jan_pkg::lane_t o;
    logic fits;
    logic [jan_pkg::SAMPLE_BITS:0] diff;
    o    = l;
    fits = (l.rem >= {1'b0, l.div});
    diff = fits ? (l.rem - {1'b0, l.div}) : l.rem;
    o.quo = {l.quo[jan_pkg::QUO_BITS-2:0], fits};
    o.rem = {diff[jan_pkg::SAMPLE_BITS-1:0], 1'b0};
    return o;
  endfunction

  always_comb begin
    data_nxt     = up_data;
    data_nxt.x   = step(up_data.x);
    data_nxt.y   = step(up_data.y);
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

[src/jan_back.sv]
module jan_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  jan_pkg::stage_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output jan_pkg::out_t   dn_data
);

  logic          valid_r;
  jan_pkg::out_t data_r;
  jan_pkg::out_t data_nxt;

  function automatic logic [jan_pkg::LEVEL_BITS-1:0] level_of(input jan_pkg::lane_t l);
    logic [jan_pkg::LEVEL_BITS:0] sum;
    logic [jan_pkg::LEVEL_BITS-1:0] lv;
    sum = {1'b0, jan_pkg::LEVEL_CENTRE} + {1'b0, l.quo};
    lv  = jan_pkg::LEVEL_MIN;
    unique case (l.mode)
      jan_pkg::MODE_BELOW: lv = jan_pkg::LEVEL_MIN;
      jan_pkg::MODE_LOWER: lv = l.quo;
      jan_pkg::MODE_UPPER: lv = sum[jan_pkg::LEVEL_BITS] ? jan_pkg::LEVEL_MAX
                                                         : sum[jan_pkg::LEVEL_BITS-1:0];
      jan_pkg::MODE_FLAT:  lv = jan_pkg::LEVEL_CENTRE;
      jan_pkg::MODE_ABOVE: lv = jan_pkg::LEVEL_MAX;
      default:             lv = jan_pkg::LEVEL_MIN;
    endcase
    return lv;
  endfunction

  function automatic logic [jan_pkg::GRADE_BITS-1:0] grade_of(
    input logic [jan_pkg::LEVEL_BITS-1:0] lv
  );
    logic [jan_pkg::GRADE_BITS-1:0] g;
    priority if (lv < jan_pkg::GRADE_EDGE_1)  g = 3'd1;
    else if (lv < jan_pkg::GRADE_EDGE_2)      g = 3'd2;
    else if (lv < jan_pkg::GRADE_EDGE_3)      g = 3'd3;
    else if (lv < jan_pkg::GRADE_EDGE_4)      g = 3'd4;
    else if (lv < jan_pkg::GRADE_EDGE_5)      g = 3'd5;
    else if (lv <= jan_pkg::GRADE_EDGE_6)     g = 3'd6;
    else                                      g = 3'd7;
    return g;
  endfunction

  always_comb begin
    data_nxt.x_level     = level_of(up_data.x);
    data_nxt.y_level     = level_of(up_data.y);
    data_nxt.x_grade     = grade_of(data_nxt.x_level);
    data_nxt.y_grade     = grade_of(data_nxt.y_level);
    data_nxt.calib_error = up_data.err;
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

[src/joystick_axis_normalize_grade.sv]
// Channel   Direction  Handshake               Word
// in_       input      in_valid / in_ready     in_data: x_sample, y_sample
// out_      output     out_valid / out_ready   out_data: levels, grades, calib_error
// cfg_      input      cfg_valid / cfg_ready   cfg_index, cfg_data (always ready)
//
// One word enters per cycle and a result leaves per cycle when out_ready is held high.
// The path holds one setup stage, eight divider cells and one output register.
// The divider chain sets the depth, one quotient bit per cell for both axes at once.
// Reset clears every stage's valid flag and loads the default calibration points.
// A stall holds only the stages behind a full one; empty stages keep filling, so in_ready
// stays high while there is room anywhere in the chain.
module joystick_axis_normalize_grade (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  jan_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output jan_pkg::out_t                       out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [jan_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [jan_pkg::SAMPLE_BITS-1:0]     cfg_data
);

  // Calibration registers. The user must change them only while the pipeline is empty, so
  // the setup stage may read them directly; the block itself does not enforce this.
  jan_pkg::cal_t cal_r;
  jan_pkg::cal_t cal_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cal_nxt = cal_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        jan_pkg::REG_X_LOW:    cal_nxt.x_low    = cfg_data;
        jan_pkg::REG_X_CENTRE: cal_nxt.x_centre = cfg_data;
        jan_pkg::REG_X_HIGH:   cal_nxt.x_high   = cfg_data;
        jan_pkg::REG_Y_LOW:    cal_nxt.y_low    = cfg_data;
        jan_pkg::REG_Y_CENTRE: cal_nxt.y_centre = cfg_data;
        jan_pkg::REG_Y_HIGH:   cal_nxt.y_high   = cfg_data;
        default:               cal_nxt          = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r.x_low    <= jan_pkg::RST_LOW;
      cal_r.x_centre <= jan_pkg::RST_CENTRE;
      cal_r.x_high   <= jan_pkg::RST_HIGH;
      cal_r.y_low    <= jan_pkg::RST_LOW;
      cal_r.y_centre <= jan_pkg::RST_CENTRE;
      cal_r.y_high   <= jan_pkg::RST_HIGH;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  // Handshake signals along the chain: index 0 is the setup stage output,
  // index k is the output of divider cell k.
  logic            st_valid [jan_pkg::DIV_STEPS+1];
  logic            st_ready [jan_pkg::DIV_STEPS+1];
  jan_pkg::stage_t st_data  [jan_pkg::DIV_STEPS+1];

  // The setup stage compares each sample against its axis points and
  // prepares the offset and span that the divider cells work on.
  jan_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .cal      (cal_r),
    .dn_valid (st_valid[0]),
    .dn_ready (st_ready[0]),
    .dn_data  (st_data[0])
  );

  // Each cell resolves one quotient bit of offset * 128 / span, MSB first.
  for (genvar k = 0; k < jan_pkg::DIV_STEPS; k++) begin : g_cell
    jan_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (st_valid[k]),
      .up_ready (st_ready[k]),
      .up_data  (st_data[k]),
      .dn_valid (st_valid[k+1]),
      .dn_ready (st_ready[k+1]),
      .dn_data  (st_data[k+1])
    );
  end

  // The output stage turns the quotient into a level, grades it, and holds
  // the finished word until the consumer takes it.
  jan_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (st_valid[jan_pkg::DIV_STEPS]),
    .up_ready (st_ready[jan_pkg::DIV_STEPS]),
    .up_data  (st_data[jan_pkg::DIV_STEPS]),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (out_data)
  );

endmodule
